// File: sv/c8x_pkg.sv
// Package: shared types, opcode codes and constants for the CHIP-8 execute unit.
`timescale 1ns / 1ps
`default_nettype none
package c8x_pkg;

   // Defaults
   localparam int          STACK_DEPTH_DEF = 16;
   localparam logic [11:0] PROG_START_RST  = 12'h200;

   // Result status
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNIMPL  = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   // Opcode groups (top nibble)
   localparam logic [3:0] GRP_SYS  = 4'h0;
   localparam logic [3:0] GRP_JP   = 4'h1;
   localparam logic [3:0] GRP_CALL = 4'h2;
   localparam logic [3:0] GRP_SEI  = 4'h3;
   localparam logic [3:0] GRP_SNEI = 4'h4;
   localparam logic [3:0] GRP_SER  = 4'h5;
   localparam logic [3:0] GRP_LDI  = 4'h6;
   localparam logic [3:0] GRP_ADDI = 4'h7;
   localparam logic [3:0] GRP_ALU  = 4'h8;
   localparam logic [3:0] GRP_SNER = 4'h9;
   localparam logic [3:0] GRP_LDIX = 4'hA;
   localparam logic [3:0] GRP_JPV0 = 4'hB;
   localparam logic [3:0] GRP_RND  = 4'hC;
   localparam logic [3:0] GRP_DRW  = 4'hD;
   localparam logic [3:0] GRP_KEY  = 4'hE;
   localparam logic [3:0] GRP_MISC = 4'hF;

   // ALU sub-opcodes (low nibble of 8xy_)
   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   // Low-byte codes
   localparam logic [7:0] SYS_CLS     = 8'hE0;
   localparam logic [7:0] SYS_RET     = 8'hEE;
   localparam logic [7:0] KEY_SKP     = 8'h9E;
   localparam logic [7:0] KEY_SKNP    = 8'hA1;
   localparam logic [7:0] FX_LD_DT    = 8'h07;
   localparam logic [7:0] FX_WAIT_KEY = 8'h0A;
   localparam logic [7:0] FX_SET_DT   = 8'h15;
   localparam logic [7:0] FX_SET_ST   = 8'h18;
   localparam logic [7:0] FX_ADD_I    = 8'h1E;
   localparam logic [7:0] FX_FONT     = 8'h29;
   localparam logic [7:0] FX_BCD      = 8'h33;
   localparam logic [7:0] FX_STORE    = 8'h55;
   localparam logic [7:0] FX_LOAD     = 8'h65;

   localparam logic [3:0] VF_IDX = 4'hF;

   // Operands handed to the execute unit
   typedef struct packed {
      logic [15:0] instr;
      logic [7:0]  rnd;
      logic [7:0]  vx;
      logic [7:0]  vy;          // V0 for Bnnn
      logic [15:0] pc;
      logic [15:0] index;
      logic [7:0]  delay;
      logic [15:0] stack_top;
      logic        stack_full;
      logic        stack_empty;
   } exec_in_type;

   // Results and write-back controls from the execute unit
   typedef struct packed {
      logic [15:0] npc;
      status_type  status;
      logic        rw;
      logic [7:0]  rval;
      logic        fw;
      logic        fval;
      logic [15:0] index;
      logic        reg_we;      // write Vx in the register file (x other than F)
      logic        vf_we;
      logic [7:0]  vf_val;
      logic        delay_we;
      logic        sound_we;
      logic        push;
      logic        pop;
   } exec_out_type;

endpackage
`default_nettype wire

// File: sv/chip8_instruction_execute_top.sv
// Top level: CHIP-8 instruction execute unit with register file and return stack.
// Each instruction beat passes an accept stage and an execute stage: in the accept cycle the register file
// (two copies, one for Vx and one for Vy or V0) and the return stack are read from
// synchronous memories; then the result is computed, and once the output register is free it is written back and
// placed in the output register. A new beat is accepted in the cycle after
// write-back, so the unit cannot take a new instruction before the last one is
// written back; a stalled result holds the
// execute stage until the output register frees. V0..VE are cleared by per-entry
// valid bits, VF is a flip-flop, so there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module chip8_instruction_execute_top #(
   parameter int STACK_DEPTH = c8x_pkg::STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_instruction,
   input  wire logic [7:0]  req_random_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_next_pc,
   output logic [1:0]       rsp_status,
   output logic             rsp_reg_written,
   output logic [3:0]       rsp_reg_index,
   output logic [7:0]       rsp_reg_value,
   output logic             rsp_flag_written,
   output logic             rsp_flag_value,
   output logic [15:0]      rsp_index_value,
   input  wire logic        csr_wr_en,
   input  wire logic [11:0] csr_wr_data
);

   localparam int SP_W  = $clog2(STACK_DEPTH);
   localparam int LVL_W = $clog2(STACK_DEPTH + 1);

   // Handshake and stage control
   logic        req_fire;
   logic        advance;
   logic        stage_valid_ff, stage_valid_in;
   logic [15:0] instr_ff;
   logic [7:0]  rnd_ff;

   // Architectural state in flip-flops
   logic [11:0]      prog_start_ff;
   logic [15:0]      pc_ff;
   logic [15:0]      index_ff;
   logic [7:0]       vf_ff;
   logic [7:0]       delay_ff;
   logic [7:0]       sound_ff;
   logic [LVL_W-1:0] level_ff;
   logic [LVL_W-1:0] level_dec;
   logic [15:0]      rf_valid_ff;

   // Memory ports
   logic [3:0]      req_x;
   logic [3:0]      req_ysel;
   logic [3:0]      stg_x;
   logic [3:0]      stg_ysel;
   logic [7:0]      rfa_data;
   logic [7:0]      rfb_data;
   logic [15:0]     stk_data;
   logic            rf_we;

   c8x_pkg::exec_in_type  ex_in;
   c8x_pkg::exec_out_type ex_out;

   // Output register
   logic                rsp_valid_ff;
   logic [15:0]         npc_ff;
   c8x_pkg::status_type status_ff;
   logic                rw_ff;
   logic [3:0]          ridx_ff;
   logic [7:0]          rval_ff;
   logic                fw_ff;
   logic                fval_ff;
   logic [15:0]         idx_out_ff;

   assign req_ready = !stage_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);

   // Read addresses: Bnnn reads V0 on the second port
   assign req_x    = req_instruction[11:8];
   assign req_ysel = (req_instruction[15:12] == c8x_pkg::GRP_JPV0) ? 4'd0
                                                                   : req_instruction[7:4];
   assign stg_x    = instr_ff[11:8];
   assign stg_ysel = (instr_ff[15:12] == c8x_pkg::GRP_JPV0) ? 4'd0 : instr_ff[7:4];
   assign level_dec = level_ff - LVL_W'(1);
   assign rf_we     = advance && ex_out.reg_we;

   // Register file, two copies written together
   c8x_ram #(.WIDTH(8), .DEPTH(16)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (stg_x),
      .wr_data (ex_out.rval),
      .rd_en   (req_fire),
      .rd_addr (req_x),
      .rd_data (rfa_data)
   );

   c8x_ram #(.WIDTH(8), .DEPTH(16)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (stg_x),
      .wr_data (ex_out.rval),
      .rd_en   (req_fire),
      .rd_addr (req_ysel),
      .rd_data (rfb_data)
   );

   // Return stack: push at level, pop reads level-1
   c8x_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (advance && ex_out.push),
      .wr_addr (level_ff[SP_W-1:0]),
      .wr_data (pc_ff),
      .rd_en   (req_fire),
      .rd_addr (level_dec[SP_W-1:0]),
      .rd_data (stk_data)
   );

   // Operand assembly; unwritten entries read as zero
   always_comb begin
      ex_in.instr       = instr_ff;
      ex_in.rnd         = rnd_ff;
      ex_in.vx          = (stg_x == c8x_pkg::VF_IDX) ? vf_ff
                        : (rf_valid_ff[stg_x] ? rfa_data : 8'd0);
      ex_in.vy          = (stg_ysel == c8x_pkg::VF_IDX) ? vf_ff
                        : (rf_valid_ff[stg_ysel] ? rfb_data : 8'd0);
      ex_in.pc          = pc_ff;
      ex_in.index       = index_ff;
      ex_in.delay       = delay_ff;
      ex_in.stack_top   = stk_data;
      ex_in.stack_full  = (level_ff >= LVL_W'(STACK_DEPTH));
      ex_in.stack_empty = (level_ff == '0) || (level_ff > LVL_W'(STACK_DEPTH));
   end

   c8x_exec u_exec (
      .ex_in  (ex_in),
      .ex_out (ex_out)
   );

   // Execute stage occupancy
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         instr_ff <= req_instruction;
         rnd_ff   <= req_random_value;
      end
   end

   // State write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         prog_start_ff <= c8x_pkg::PROG_START_RST;
         pc_ff         <= {4'd0, c8x_pkg::PROG_START_RST};
         index_ff      <= 16'd0;
         vf_ff         <= 8'd0;
         delay_ff      <= 8'd0;
         sound_ff      <= 8'd0;
         level_ff      <= '0;
         rf_valid_ff   <= 16'd0;
      end else if (csr_wr_en) begin
         prog_start_ff <= csr_wr_data;
         pc_ff         <= {4'd0, csr_wr_data};
      end else if (advance) begin
         pc_ff    <= ex_out.npc;
         index_ff <= ex_out.index;
         if (ex_out.vf_we) vf_ff <= ex_out.vf_val;
         if (ex_out.delay_we) delay_ff <= ex_in.vx;
         if (ex_out.sound_we) sound_ff <= ex_in.vx;
         if (ex_out.push) begin
            level_ff <= level_ff + LVL_W'(1);
         end else if (ex_out.pop) begin
            level_ff <= level_dec;
         end
         if (ex_out.reg_we) rf_valid_ff[stg_x] <= 1'b1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         npc_ff     <= ex_out.npc;
         status_ff  <= ex_out.status;
         rw_ff      <= ex_out.rw;
         ridx_ff    <= ex_out.rw ? stg_x : 4'd0;
         rval_ff    <= ex_out.rval;
         fw_ff      <= ex_out.fw;
         fval_ff    <= ex_out.fval;
         idx_out_ff <= ex_out.index;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = npc_ff;
   assign rsp_status       = status_ff;
   assign rsp_reg_written  = rw_ff;
   assign rsp_reg_index    = ridx_ff;
   assign rsp_reg_value    = rval_ff;
   assign rsp_flag_written = fw_ff;
   assign rsp_flag_value   = fval_ff;
   assign rsp_index_value  = idx_out_ff;

   // Checks
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(STACK_DEPTH))
      else $error("return stack level beyond depth");

   a_fail_no_write: assert property (@(posedge clock) disable iff (reset)
      advance && ex_out.status != c8x_pkg::ST_OK |->
         !ex_out.reg_we && !ex_out.vf_we && !ex_out.push && !ex_out.pop)
      else $error("state written on a failed instruction");

   a_ready_after_wb: assert property (@(posedge clock) disable iff (reset)
      advance && !req_fire |=> req_ready)
      else $error("input not ready after write-back");

   a_push_level: assert property (@(posedge clock) disable iff (reset)
      advance && ex_out.push && !csr_wr_en |=>
         level_ff == $past(level_ff) + LVL_W'(1))
      else $error("stack level not bumped on call");

endmodule
`default_nettype wire

// File: sv/c8x_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module c8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/c8x_exec.sv
// Execute unit: decodes one instruction word and works out its results.
`timescale 1ns / 1ps
`default_nettype none
module c8x_exec (
   input  wire c8x_pkg::exec_in_type  ex_in,
   output c8x_pkg::exec_out_type      ex_out
);

   logic [3:0]  grp;
   logic [3:0]  x;
   logic [3:0]  nib;
   logic [7:0]  kk;
   logic [11:0] nnn;
   logic [15:0] pc_next;
   logic [15:0] pc_skip;
   logic [8:0]  sum9;
   logic [7:0]  diff_xy;
   logic [7:0]  diff_yx;
   logic [15:0] idx_sum;
   logic [15:0] npc;
   c8x_pkg::status_type status;
   logic        rw;
   logic        fw;
   logic [7:0]  rval;
   logic        fval;
   logic [15:0] index;
   logic        delay_we;
   logic        sound_we;
   logic        push;
   logic        pop;
   logic        is_add;
   logic        x_is_vf;

   // Field split and shared arithmetic
   always_comb begin
      grp     = ex_in.instr[15:12];
      x       = ex_in.instr[11:8];
      nib     = ex_in.instr[3:0];
      kk      = ex_in.instr[7:0];
      nnn     = ex_in.instr[11:0];
      pc_next = ex_in.pc + 16'd2;
      pc_skip = ex_in.pc + 16'd4;
      sum9    = {1'b0, ex_in.vx} + {1'b0, ex_in.vy};
      diff_xy = ex_in.vx - ex_in.vy;
      diff_yx = ex_in.vy - ex_in.vx;
      idx_sum = ex_in.index + {8'd0, ex_in.vx};
   end

   // Decode and execute
   always_comb begin
      npc      = pc_next;
      status   = c8x_pkg::ST_OK;
      rw       = 1'b0;
      fw       = 1'b0;
      rval     = 8'd0;
      fval     = 1'b0;
      index    = ex_in.index;
      delay_we = 1'b0;
      sound_we = 1'b0;
      push     = 1'b0;
      pop      = 1'b0;
      case (grp)
         c8x_pkg::GRP_SYS: begin
            if (kk == c8x_pkg::SYS_CLS) begin
               status = c8x_pkg::ST_UNIMPL;
            end else if (kk == c8x_pkg::SYS_RET) begin
               if (ex_in.stack_empty) begin
                  status = c8x_pkg::ST_INVALID;
               end else begin
                  pop = 1'b1;
                  npc = ex_in.stack_top + 16'd2;
               end
            end else begin
               status = c8x_pkg::ST_INVALID;
            end
         end
         c8x_pkg::GRP_JP: npc = {4'd0, nnn};
         c8x_pkg::GRP_CALL: begin
            if (ex_in.stack_full) begin
               status = c8x_pkg::ST_INVALID;
            end else begin
               push = 1'b1;
               npc  = {4'd0, nnn};
            end
         end
         c8x_pkg::GRP_SEI: begin
            if (ex_in.vx == kk) npc = pc_skip;
         end
         c8x_pkg::GRP_SNEI: begin
            if (ex_in.vx != kk) npc = pc_skip;
         end
         c8x_pkg::GRP_SER: begin
            if (ex_in.vx == ex_in.vy) npc = pc_skip;
         end
         c8x_pkg::GRP_LDI: begin
            rw   = 1'b1;
            rval = kk;
         end
         c8x_pkg::GRP_ADDI: begin
            rw   = 1'b1;
            rval = ex_in.vx + kk;
         end
         c8x_pkg::GRP_ALU: begin
            case (nib)
               c8x_pkg::ALU_MOV: begin rw = 1'b1; rval = ex_in.vy; end
               c8x_pkg::ALU_OR:  begin rw = 1'b1; rval = ex_in.vx | ex_in.vy; end
               c8x_pkg::ALU_AND: begin rw = 1'b1; rval = ex_in.vx & ex_in.vy; end
               c8x_pkg::ALU_XOR: begin rw = 1'b1; rval = ex_in.vx ^ ex_in.vy; end
               c8x_pkg::ALU_ADD: begin
                  rw = 1'b1; rval = sum9[7:0];
                  fw = 1'b1; fval = sum9[8];
               end
               c8x_pkg::ALU_SUB: begin
                  rw = 1'b1; rval = diff_xy;
                  fw = 1'b1; fval = (ex_in.vx > ex_in.vy);
               end
               c8x_pkg::ALU_SHR: begin
                  rw = 1'b1; rval = {1'b0, ex_in.vx[7:1]};
                  fw = 1'b1; fval = ex_in.vx[0];
               end
               c8x_pkg::ALU_SBN: begin
                  rw = 1'b1; rval = diff_yx;
                  fw = 1'b1; fval = (ex_in.vy > ex_in.vx);
               end
               c8x_pkg::ALU_SHL: begin
                  rw = 1'b1; rval = {ex_in.vx[6:0], 1'b0};
                  fw = 1'b1; fval = ex_in.vx[7];
               end
               default: status = c8x_pkg::ST_INVALID;
            endcase
         end
         c8x_pkg::GRP_SNER: begin
            if (ex_in.vx != ex_in.vy) npc = pc_skip;
         end
         c8x_pkg::GRP_LDIX: index = {4'd0, nnn};
         c8x_pkg::GRP_JPV0: npc = {4'd0, nnn} + {8'd0, ex_in.vy};
         c8x_pkg::GRP_RND: begin
            rw   = 1'b1;
            rval = ex_in.rnd & kk;
         end
         c8x_pkg::GRP_DRW: status = c8x_pkg::ST_UNIMPL;
         c8x_pkg::GRP_KEY: begin
            if (kk == c8x_pkg::KEY_SKP || kk == c8x_pkg::KEY_SKNP) begin
               status = c8x_pkg::ST_UNIMPL;
            end else begin
               status = c8x_pkg::ST_INVALID;
            end
         end
         default: begin
            case (kk)
               c8x_pkg::FX_LD_DT:  begin rw = 1'b1; rval = ex_in.delay; end
               c8x_pkg::FX_SET_DT: delay_we = 1'b1;
               c8x_pkg::FX_SET_ST: sound_we = 1'b1;
               c8x_pkg::FX_ADD_I: begin
                  fw    = 1'b1;
                  fval  = |idx_sum[15:12];
                  index = idx_sum;
               end
               c8x_pkg::FX_WAIT_KEY, c8x_pkg::FX_FONT, c8x_pkg::FX_BCD,
               c8x_pkg::FX_STORE, c8x_pkg::FX_LOAD: status = c8x_pkg::ST_UNIMPL;
               default: status = c8x_pkg::ST_INVALID;
            endcase
         end
      endcase

      // Nothing changes on an unimplemented or invalid word
      if (status != c8x_pkg::ST_OK) begin
         npc      = ex_in.pc;
         rw       = 1'b0;
         fw       = 1'b0;
         rval     = 8'd0;
         fval     = 1'b0;
         index    = ex_in.index;
         delay_we = 1'b0;
         sound_we = 1'b0;
         push     = 1'b0;
         pop      = 1'b0;
      end
   end

   // Write-back routing: VF lives outside the register file
   always_comb begin
      is_add  = (grp == c8x_pkg::GRP_ALU) && (nib == c8x_pkg::ALU_ADD);
      x_is_vf = (x == c8x_pkg::VF_IDX);

      ex_out.npc      = npc;
      ex_out.status   = status;
      ex_out.rw       = rw;
      ex_out.rval     = rval;
      ex_out.fw       = fw;
      ex_out.fval     = fval;
      ex_out.index    = index;
      ex_out.reg_we   = rw && !x_is_vf;
      ex_out.vf_we    = fw || (rw && x_is_vf);
      ex_out.delay_we = delay_we;
      ex_out.sound_we = sound_we;
      ex_out.push     = push;
      ex_out.pop      = pop;
      // add leaves its carry in VF; other ops leave the result when x is F
      if (fw && is_add) begin
         ex_out.vf_val = {7'd0, fval};
      end else if (rw && x_is_vf) begin
         ex_out.vf_val = rval;
      end else begin
         ex_out.vf_val = {7'd0, fval};
      end
   end

endmodule
`default_nettype wire

// File: tb/sv/c8x_exec_checker.sv
// Checker for the CHIP-8 execute unit: predicts each result beat and compares it.
`timescale 1ns / 1ps
module c8x_exec_checker
   import c8x_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [15:0] req_instruction,
   input  wire logic [7:0]  req_random_value,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [15:0] rsp_next_pc,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        rsp_reg_written,
   input  wire logic [3:0]  rsp_reg_index,
   input  wire logic [7:0]  rsp_reg_value,
   input  wire logic        rsp_flag_written,
   input  wire logic        rsp_flag_value,
   input  wire logic [15:0] rsp_index_value,
   input  wire logic        csr_wr_en,
   input  wire logic [11:0] csr_wr_data,
   output int               pending,
   output int               errors
);

   typedef struct {
      logic [15:0] next_pc;
      status_type  status;
      logic        reg_written;
      logic [3:0]  reg_index;
      logic [7:0]  reg_value;
      logic        flag_written;
      logic        flag_value;
      logic [15:0] index_value;
   } exec_result_type;

   // Architectural state as the block should hold it
   logic [7:0]   vreg [16];
   logic [15:0]  i_reg;
   logic [15:0]  pc_now;
   logic [11:0]  start_pc;
   logic [15:0]  ret_stack [STACK_DEPTH];
   int           depth;
   logic [7:0]   delay_t;
   logic [7:0]   sound_t;

   exec_result_type due_results [$];
   int              mismatches = 0;
   int              due_count  = 0;

   assign pending = due_count;
   assign errors  = mismatches;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic clear_state();
      for (int i = 0; i < 16; i++) vreg[i] = 8'h00;
      i_reg    = 16'h0000;
      start_pc = PROG_START_RST;
      pc_now   = {4'h0, PROG_START_RST};
      depth    = 0;
      delay_t  = 8'h00;
      sound_t  = 8'h00;
   endtask

   // Execute one instruction word against the state and return its result beat
   function automatic exec_result_type execute_word(input logic [15:0] op,
                                                    input logic [7:0] rb);
      exec_result_type r;
      logic [3:0]   grp, x, y, sub;
      logic [7:0]   kk, vx, vy, wval;
      logic [11:0]  nnn;
      logic [15:0]  npc, skip_pc, sum;
      logic [8:0]   wide;
      logic         rw, fw, fval;
      status_type   st;
      grp  = op[15:12];
      x    = op[11:8];
      y    = op[7:4];
      sub  = op[3:0];
      kk   = op[7:0];
      nnn  = op[11:0];
      vx   = vreg[x];
      vy   = vreg[y];
      npc     = pc_now + 16'd2;
      skip_pc = pc_now + 16'd4;
      st   = ST_OK;
      rw   = 1'b0;
      fw   = 1'b0;
      wval = 8'h00;
      fval = 1'b0;
      case (grp)
         GRP_SYS: begin
            if (kk == SYS_CLS) begin
               st = ST_UNIMPL;
            end else if (kk == SYS_RET) begin
               if (depth == 0) begin
                  st = ST_INVALID;
               end else begin
                  depth = depth - 1;
                  npc   = ret_stack[depth] + 16'd2;
               end
            end else begin
               st = ST_INVALID;
            end
         end
         GRP_JP:   npc = {4'h0, nnn};
         GRP_CALL: begin
            if (depth >= STACK_DEPTH) begin
               st = ST_INVALID;
            end else begin
               ret_stack[depth] = pc_now;
               depth = depth + 1;
               npc   = {4'h0, nnn};
            end
         end
         GRP_SEI:  if (vx == kk) npc = skip_pc;
         GRP_SNEI: if (vx != kk) npc = skip_pc;
         GRP_SER:  if (vx == vy) npc = skip_pc;
         GRP_SNER: if (vx != vy) npc = skip_pc;
         GRP_LDI:  begin rw = 1'b1; wval = kk; end
         GRP_ADDI: begin rw = 1'b1; wval = vx + kk; end
         GRP_ALU: begin
            case (sub)
               ALU_MOV: begin rw = 1'b1; wval = vy; end
               ALU_OR:  begin rw = 1'b1; wval = vx | vy; end
               ALU_AND: begin rw = 1'b1; wval = vx & vy; end
               ALU_XOR: begin rw = 1'b1; wval = vx ^ vy; end
               ALU_ADD: begin
                  wide = {1'b0, vx} + {1'b0, vy};
                  rw = 1'b1; wval = wide[7:0];
                  fw = 1'b1; fval = wide[8];
               end
               ALU_SUB: begin
                  fw = 1'b1; fval = (vx > vy);
                  rw = 1'b1; wval = vx - vy;
               end
               ALU_SHR: begin
                  fw = 1'b1; fval = vx[0];
                  rw = 1'b1; wval = vx >> 1;
               end
               ALU_SBN: begin
                  fw = 1'b1; fval = (vy > vx);
                  rw = 1'b1; wval = vy - vx;
               end
               ALU_SHL: begin
                  fw = 1'b1; fval = vx[7];
                  rw = 1'b1; wval = {vx[6:0], 1'b0};
               end
               default: st = ST_INVALID;
            endcase
         end
         GRP_LDIX: i_reg = {4'h0, nnn};
         GRP_JPV0: npc = {4'h0, nnn} + {8'h00, vreg[0]};
         GRP_RND:  begin rw = 1'b1; wval = rb & kk; end
         GRP_DRW:  st = ST_UNIMPL;
         GRP_KEY:  st = (kk == KEY_SKP || kk == KEY_SKNP) ? ST_UNIMPL : ST_INVALID;
         default: begin
            case (kk)
               FX_LD_DT:  begin rw = 1'b1; wval = delay_t; end
               FX_SET_DT: delay_t = vx;
               FX_SET_ST: sound_t = vx;
               FX_ADD_I: begin
                  sum   = i_reg + {8'h00, vx};
                  fw    = 1'b1;
                  fval  = (sum > 16'h0FFF);
                  i_reg = sum;
               end
               FX_WAIT_KEY, FX_FONT, FX_BCD, FX_STORE, FX_LOAD: st = ST_UNIMPL;
               default: st = ST_INVALID;
            endcase
         end
      endcase

      // Write-back: with VF as destination the later write wins
      if (st != ST_OK) begin
         npc  = pc_now;
         rw   = 1'b0;
         fw   = 1'b0;
         wval = 8'h00;
         fval = 1'b0;
      end else begin
         if (grp == GRP_ALU && sub == ALU_ADD) begin
            vreg[x]      = wval;
            vreg[VF_IDX] = {7'd0, fval};
         end else begin
            if (fw) vreg[VF_IDX] = {7'd0, fval};
            if (rw) vreg[x] = wval;
         end
         pc_now = npc;
      end

      r.next_pc      = npc;
      r.status       = st;
      r.reg_written  = rw;
      r.reg_index    = rw ? x : 4'h0;
      r.reg_value    = wval;
      r.flag_written = fw;
      r.flag_value   = fval;
      r.index_value  = i_reg;
      return r;
   endfunction

   // Watch both channels and the register port at every rising edge
   always @(posedge clock) begin : watch
      exec_result_type want;
      if (reset) begin
         clear_state();
         due_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               report_mismatch("unrequested result, next_pc", rsp_next_pc, 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_next_pc !== want.next_pc)
                  report_mismatch("next_pc", rsp_next_pc, want.next_pc);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_reg_written !== want.reg_written)
                  report_mismatch("reg_written", rsp_reg_written, want.reg_written);
               if (rsp_reg_index !== want.reg_index)
                  report_mismatch("reg_index", rsp_reg_index, want.reg_index);
               if (rsp_reg_value !== want.reg_value)
                  report_mismatch("reg_value", rsp_reg_value, want.reg_value);
               if (rsp_flag_written !== want.flag_written)
                  report_mismatch("flag_written", rsp_flag_written, want.flag_written);
               if (rsp_flag_value !== want.flag_value)
                  report_mismatch("flag_value", rsp_flag_value, want.flag_value);
               if (rsp_index_value !== want.index_value)
                  report_mismatch("index_value", rsp_index_value, want.index_value);
            end
         end
         // program start write also reloads the program counter
         if (csr_wr_en) begin
            start_pc = csr_wr_data;
            pc_now   = {4'h0, csr_wr_data};
         end
         if (req_valid && req_ready)
            due_results.push_back(execute_word(req_instruction, req_random_value));
      end
      due_count <= due_results.size();
   end

endmodule

// File: tb/sv/tb.sv
// Testbench top: clock, reset, stimulus and verdict for the CHIP-8 execute unit.
`timescale 1ns / 1ps
module tb;
   import c8x_pkg::*;

   localparam int HOLD_CYCLES = 60;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_instruction;
   logic [7:0]  req_random_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_next_pc;
   logic [1:0]  rsp_status;
   logic        rsp_reg_written;
   logic [3:0]  rsp_reg_index;
   logic [7:0]  rsp_reg_value;
   logic        rsp_flag_written;
   logic        rsp_flag_value;
   logic [15:0] rsp_index_value;
   logic        csr_wr_en;
   logic [11:0] csr_wr_data;

   int          pending;
   int          errors;
   logic        req_eager = 1'b0;
   logic        rsp_eager = 1'b0;
   logic        long_hold = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   chip8_instruction_execute_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_instruction  (req_instruction),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_status       (rsp_status),
      .rsp_reg_written  (rsp_reg_written),
      .rsp_reg_index    (rsp_reg_index),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_flag_written (rsp_flag_written),
      .rsp_flag_value   (rsp_flag_value),
      .rsp_index_value  (rsp_index_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   c8x_exec_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_instruction  (req_instruction),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_status       (rsp_status),
      .rsp_reg_written  (rsp_reg_written),
      .rsp_reg_index    (rsp_reg_index),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_flag_written (rsp_flag_written),
      .rsp_flag_value   (rsp_flag_value),
      .rsp_index_value  (rsp_index_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .pending          (pending),
      .errors           (errors)
   );

   // Offer one instruction beat after a random gap; returns at the falling edge after accept
   task automatic send_word(input logic [15:0] op);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_instruction  = op;
      req_random_value = 8'($urandom);
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding result
   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_start(input logic [11:0] val);
      csr_wr_data = val;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Random instruction mix, weighted towards well-formed register traffic
   function automatic logic [15:0] pick_word();
      logic [3:0] x, y, sub;
      logic [7:0] kk;
      int         sel;
      x   = ($urandom_range(0, 3) == 0) ? VF_IDX : 4'($urandom_range(0, 15));
      y   = 4'($urandom_range(0, 15));
      kk  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 10) return {GRP_LDI, x, kk};
      else if (sel < 16) return {GRP_ADDI, x, kk};
      else if (sel < 36) begin
         case ($urandom_range(0, 9))
            0: sub = ALU_MOV;
            1: sub = ALU_OR;
            2: sub = ALU_AND;
            3: sub = ALU_XOR;
            4: sub = ALU_ADD;
            5: sub = ALU_SUB;
            6: sub = ALU_SHR;
            7: sub = ALU_SBN;
            8: sub = ALU_SHL;
            default: sub = 4'($urandom);
         endcase
         return {GRP_ALU, x, y, sub};
      end
      else if (sel < 40) return {GRP_SEI, x, kk};
      else if (sel < 44) return {GRP_SNEI, x, kk};
      else if (sel < 47) return {GRP_SER, x, y, 4'($urandom)};
      else if (sel < 50) return {GRP_SNER, x, y, 4'($urandom)};
      else if (sel < 54) return {GRP_LDIX, 12'($urandom)};
      else if (sel < 58) return {GRP_MISC, x, FX_ADD_I};
      else if (sel < 60) return {GRP_JPV0, 12'($urandom)};
      else if (sel < 62) return {GRP_JP, 12'($urandom)};
      else if (sel < 65) return {GRP_RND, x, 8'($urandom)};
      else if (sel < 67) return {GRP_MISC, x, FX_LD_DT};
      else if (sel < 69) return {GRP_MISC, x, FX_SET_DT};
      else if (sel < 71) return {GRP_MISC, x, FX_SET_ST};
      else if (sel < 78) return {GRP_CALL, 12'($urandom)};
      else if (sel < 85) return {GRP_SYS, 4'($urandom), SYS_RET};
      else if (sel < 87) return {GRP_SYS, 4'($urandom), SYS_CLS};
      else if (sel < 88) return {GRP_SYS, 12'($urandom)};
      else if (sel < 89) return {GRP_DRW, 12'($urandom)};
      else if (sel < 91) return {GRP_KEY, x, ($urandom_range(0, 1) == 0) ? KEY_SKP : KEY_SKNP};
      else if (sel < 92) return {GRP_KEY, x, 8'($urandom)};
      else if (sel < 95) begin
         case ($urandom_range(0, 4))
            0: kk = FX_WAIT_KEY;
            1: kk = FX_FONT;
            2: kk = FX_BCD;
            3: kk = FX_STORE;
            default: kk = FX_LOAD;
         endcase
         return {GRP_MISC, x, kk};
      end
      else if (sel < 96) return {GRP_MISC, x, 8'($urandom)};
      return 16'($urandom);
   endfunction

   // Result side: random stall per beat (none when rsp_eager is set), plus a long hold-off when asked
   initial begin : rsp_side
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         stall = rsp_eager ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin : stimulus
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_instruction  = 16'h0000;
      req_random_value = 8'h00;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 12'h000;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Directed, at the reset program start
      // clear screen is unimplemented; return on an empty stack and stray sys words are invalid
      send_word({GRP_SYS, 4'h0, SYS_CLS});
      send_word({GRP_SYS, 4'h0, SYS_RET});
      send_word({GRP_SYS, 4'hA, 8'hBC});
      // ALU with carry, borrow, both shifts and an undefined sub-opcode
      send_word({GRP_LDI, 4'h1, 8'hFF});
      send_word({GRP_LDI, 4'h2, 8'h01});
      send_word({GRP_ALU, 4'h1, 4'h2, ALU_ADD});
      send_word({GRP_ALU, 4'h1, 4'h2, ALU_SUB});
      send_word({GRP_ALU, 4'h2, 4'h1, ALU_SBN});
      send_word({GRP_ALU, 4'h1, 4'h2, ALU_SHR});
      send_word({GRP_ALU, 4'h2, 4'h1, ALU_SHL});
      send_word({GRP_ALU, 4'h1, 4'h2, 4'h8});
      // VF as destination: the add keeps its flag, the subtract keeps its result
      send_word({GRP_LDI, VF_IDX, 8'hC8});
      send_word({GRP_LDI, 4'h3, 8'h38});
      send_word({GRP_ALU, VF_IDX, 4'h3, ALU_ADD});
      send_word({GRP_ALU, VF_IDX, 4'h3, ALU_SUB});
      // skips, index add past 0xFFF, jump plus V0, random, draw and the delay timer
      send_word({GRP_SEI, 4'h3, 8'h38});
      send_word({GRP_SER, 4'h1, 4'h1, 4'h0});
      send_word({GRP_LDIX, 12'hFFF});
      send_word({GRP_MISC, 4'h3, FX_ADD_I});
      send_word({GRP_JPV0, 12'hFFF});
      send_word({GRP_RND, 4'h4, 8'hA5});
      send_word({GRP_DRW, 12'h123});
      send_word({GRP_MISC, 4'h3, FX_SET_DT});
      send_word({GRP_MISC, 4'h5, FX_LD_DT});
      // call then return, a plain jump and an unknown Fx code
      send_word({GRP_CALL, 12'hABC});
      send_word({GRP_SYS, 4'h0, SYS_RET});
      send_word({GRP_JP, 12'hFFE});
      send_word({GRP_MISC, 4'h0, 8'hFF});
      drain();

      // Fill the return stack past its depth, then unwind past empty, back to back
      write_start(12'hFFF);
      req_eager = 1'b1;
      rsp_eager = 1'b1;
      repeat (STACK_DEPTH_DEF + 1) send_word({GRP_CALL, 12'($urandom)});
      repeat (STACK_DEPTH_DEF + 1) send_word({GRP_SYS, 4'h0, SYS_RET});
      drain();

      // Index register walks up until it wraps at 16 bits
      write_start(12'h000);
      req_eager = 1'b0;
      rsp_eager = 1'b0;
      send_word({GRP_LDI, 4'h3, 8'hFF});
      send_word({GRP_LDIX, 12'hFFF});
      repeat (245) send_word({GRP_MISC, 4'h3, FX_ADD_I});
      drain();

      // Result side holds off while beats keep coming
      write_start(12'($urandom));
      req_eager = 1'b1;
      long_hold = 1'b1;
      repeat (30) send_word(pick_word());
      drain();

      // Random mix, with stretches of no idling and a mid-run program start change
      for (int i = 0; i < 400; i++) begin
         if (i % 50 == 0) begin
            req_eager = ($urandom_range(0, 3) == 0);
            rsp_eager = ($urandom_range(0, 3) == 0);
         end
         if (i == 200) begin
            drain();
            write_start(12'($urandom));
         end
         send_word(pick_word());
      end
      drain();
      repeat (8) @(negedge clock);

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #3_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
sv/c8x_pkg.sv
sv/c8x_ram.sv
sv/c8x_exec.sv
sv/chip8_instruction_execute_top.sv
tb/sv/c8x_exec_checker.sv
tb/sv/tb.sv
